// ----- rtl/dnd_pkg.sv -----
// DNS decompressor constants: error codes, actions, wire markers, chunk geometry.
package dnd_pkg;

    // Error codes reported on the last result of a decode
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_JUMPS     = 2'd1;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
    localparam logic [1:0] ERR_RANGE     = 2'd3;

    // Input item actions
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Wire format: length bytes at or above this value open a compression pointer
    localparam logic [7:0] PTR_TAG  = 8'd192;
    // Label separator in the text form
    localparam logic [7:0] DOT_CHAR = 8'h2e;

    // Text chunk geometry
    localparam int CHUNK_CHARS = 8;
    localparam int TEXT_DEPTH  = 256;

endpackage

// ----- rtl/dnd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dns_name_decompressor.sv -----
// Top level of the DNS name decompressor: packet store, label walker and text chunker.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): an item with action 0 writes
//   i_data_byte into the packet store at i_address (ignored beyond
//   the store). An item with action 1 decodes the name at i_address.
//   Output channel (o_out_valid / i_out_stall): a decode returns 1 to 32
//   items, each up to eight characters of the dotted name, first character
//   in the lowest byte. The final item has o_last set and carries the bytes
//   consumed at the start position and the error code. Any error gives a
//   single last item with zero text.
//   The packet store has one read port, so the walk reads length bytes,
//   label characters and pointer bytes one at a time. Each text chunk is
//   then gathered from the text buffer and held in the output register.
//   The block stalls its input for the whole decode.
//   A receiver stall holds the output item and the walk state unchanged.
//   Reset (synchronous, active low) returns to idle, drops any output and
//   sets the jump limit to 16; the packet store is not cleared.
//   i_cfg_we writes the jump limit; write it only while idle.
module dns_name_decompressor
    import dnd_pkg::*;
#(
    parameter int PACKET_BYTES   = 512,
    parameter int MAX_NAME_BYTES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [8:0]  i_address,
    input  logic [7:0]  i_data_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_text_chunk,
    output logic [3:0]  o_chunk_bytes,
    output logic [8:0]  o_consumed_bytes,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    localparam int ADDR_W  = $clog2(PACKET_BYTES);
    localparam int POS_W   = ($clog2(PACKET_BYTES + 1) > 14) ? $clog2(PACKET_BYTES + 1) : 14;
    localparam int CMP_W   = POS_W + 1;
    localparam int TADDR_W = $clog2(TEXT_DEPTH);

    localparam logic [CMP_W-1:0] PB_LIMIT   = CMP_W'(PACKET_BYTES);
    localparam logic [9:0]       NAME_LIMIT = 10'(MAX_NAME_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_HEAD,
        S_PTR,
        S_LABEL,
        S_TXT,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    logic [7:0]       r_max_jumps;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_jumped, n_jumped;
    logic [7:0]       r_jc, n_jc;
    logic [8:0]       r_consumed, n_consumed;
    logic [7:0]       r_tlen, n_tlen;
    logic [7:0]       r_wire, n_wire;
    logic [7:0]       r_rem, n_rem;
    logic [5:0]       r_ptr_hi, n_ptr_hi;
    // chunker
    logic [7:0]       r_base, n_base;
    logic [7:0]       r_left, n_left;
    logic [3:0]       r_j, n_j;
    logic             r_cap_vld, n_cap_vld;
    logic [2:0]       r_cap_idx, n_cap_idx;
    // output register
    logic             r_valid, n_valid;
    logic [63:0]      r_chunk, n_chunk;
    logic [3:0]       r_cbytes, n_cbytes;
    logic [8:0]       r_ocons, n_ocons;
    logic [1:0]       r_err, n_err;
    logic             r_last, n_last;

    // memory ports
    logic              pk_we, pk_re;
    logic [ADDR_W-1:0] pk_waddr, pk_raddr;
    logic [7:0]        pk_rdata;
    logic              tx_we, tx_re;
    logic [TADDR_W-1:0] tx_waddr, tx_raddr;
    logic [7:0]        tx_wdata, tx_rdata;

    logic [CMP_W-1:0] pos_ext, pos_inc, pos_len, ld_addr;
    logic [9:0]       wire_need;
    logic [3:0]       cnt;
    logic             in_take, out_take;

    dnd_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_packet (
        .i_clk  (i_clk),
        .i_we   (pk_we),
        .i_waddr(pk_waddr),
        .i_wdata(i_data_byte),
        .i_re   (pk_re),
        .i_raddr(pk_raddr),
        .o_rdata(pk_rdata)
    );

    dnd_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text (
        .i_clk  (i_clk),
        .i_we   (tx_we),
        .i_waddr(tx_waddr),
        .i_wdata(tx_wdata),
        .i_re   (tx_re),
        .i_raddr(tx_raddr),
        .o_rdata(tx_rdata)
    );

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_take = r_valid && !i_out_stall;

    // shared position arithmetic
    assign pos_ext   = CMP_W'(r_pos);
    assign pos_inc   = pos_ext + CMP_W'(1);
    assign pos_len   = pos_ext + CMP_W'(pk_rdata);
    assign ld_addr   = CMP_W'(i_address);
    assign wire_need = 10'(r_wire) + 10'(pk_rdata) + 10'd2;
    assign cnt       = (r_left >= 8'(CHUNK_CHARS)) ? 4'(CHUNK_CHARS) : r_left[3:0];

    // sequencer next state
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_jumped   = r_jumped;
        n_jc       = r_jc;
        n_consumed = r_consumed;
        n_tlen     = r_tlen;
        n_wire     = r_wire;
        n_rem      = r_rem;
        n_ptr_hi   = r_ptr_hi;
        n_base     = r_base;
        n_left     = r_left;
        n_j        = r_j;
        n_cap_vld  = r_cap_vld;
        n_cap_idx  = r_cap_idx;
        n_valid    = r_valid;
        n_chunk    = r_chunk;
        n_cbytes   = r_cbytes;
        n_ocons    = r_ocons;
        n_err      = r_err;
        n_last     = r_last;
        pk_we      = 1'b0;
        pk_waddr   = ld_addr[ADDR_W-1:0];
        pk_re      = 1'b0;
        pk_raddr   = r_pos[ADDR_W-1:0];
        tx_we      = 1'b0;
        tx_waddr   = r_tlen;
        tx_wdata   = pk_rdata;
        tx_re      = 1'b0;
        tx_raddr   = r_base + 8'(r_j);

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (i_action == ACT_LOAD) begin
                        pk_we = (ld_addr < PB_LIMIT);
                    end else begin
                        n_pos      = POS_W'(i_address);
                        n_jumped   = 1'b0;
                        n_jc       = 8'd0;
                        n_consumed = 9'd0;
                        n_tlen     = 8'd0;
                        n_wire     = 8'd0;
                        n_state    = S_FETCH;
                    end
                end
            end

            // read a length, pointer or terminator byte
            S_FETCH: begin
                if (pos_ext >= PB_LIMIT) begin
                    n_err   = ERR_RANGE;
                    n_state = S_OUT;
                end else begin
                    pk_re   = 1'b1;
                    n_state = S_HEAD;
                end
            end

            S_HEAD: begin
                if (pk_rdata == 8'd0) begin
                    // terminator: start chunking
                    if (!r_jumped) begin
                        n_consumed = r_consumed + 9'd1;
                    end
                    n_base    = 8'd0;
                    n_left    = r_tlen;
                    n_j       = 4'd0;
                    n_cap_vld = 1'b0;
                    n_chunk   = 64'd0;
                    n_state   = S_TXT;
                end else if (pk_rdata >= PTR_TAG) begin
                    if (pos_inc >= PB_LIMIT) begin
                        n_err   = ERR_RANGE;
                        n_state = S_OUT;
                    end else if (r_jc >= r_max_jumps) begin
                        n_err   = ERR_JUMPS;
                        n_state = S_OUT;
                    end else begin
                        pk_re    = 1'b1;
                        pk_raddr = pos_inc[ADDR_W-1:0];
                        n_ptr_hi = pk_rdata[5:0];
                        n_state  = S_PTR;
                    end
                end else begin
                    if (wire_need > NAME_LIMIT) begin
                        n_err   = ERR_TOO_LONG;
                        n_state = S_OUT;
                    end else if (pos_len >= PB_LIMIT) begin
                        n_err   = ERR_RANGE;
                        n_state = S_OUT;
                    end else begin
                        // separator before every label but the first
                        if (r_tlen != 8'd0) begin
                            tx_we    = 1'b1;
                            tx_wdata = DOT_CHAR;
                            n_tlen   = r_tlen + 8'd1;
                        end
                        n_wire = 8'(wire_need - 10'd1);
                        if (!r_jumped) begin
                            n_consumed = r_consumed + 9'(pk_rdata) + 9'd1;
                        end
                        pk_re    = 1'b1;
                        pk_raddr = pos_inc[ADDR_W-1:0];
                        n_pos    = pos_inc[POS_W-1:0];
                        n_rem    = pk_rdata;
                        n_state  = S_LABEL;
                    end
                end
            end

            // second pointer byte arrived: jump
            S_PTR: begin
                n_pos = POS_W'({r_ptr_hi, pk_rdata});
                if (!r_jumped) begin
                    n_consumed = r_consumed + 9'd2;
                end
                n_jumped = 1'b1;
                n_jc     = r_jc + 8'd1;
                n_state  = S_FETCH;
            end

            // copy one label character per cycle
            S_LABEL: begin
                tx_we  = 1'b1;
                n_tlen = r_tlen + 8'd1;
                n_pos  = pos_inc[POS_W-1:0];
                n_rem  = r_rem - 8'd1;
                if (r_rem == 8'd1) begin
                    n_state = S_FETCH;
                end else begin
                    pk_re    = 1'b1;
                    pk_raddr = pos_inc[ADDR_W-1:0];
                end
            end

            // gather one chunk from the text buffer
            S_TXT: begin
                if (r_cap_vld) begin
                    n_chunk[{r_cap_idx, 3'b000} +: 8] = tx_rdata;
                end
                if (r_j < cnt) begin
                    tx_re     = 1'b1;
                    n_cap_vld = 1'b1;
                    n_cap_idx = r_j[2:0];
                    n_j       = r_j + 4'd1;
                end else begin
                    n_cap_vld = 1'b0;
                    n_valid   = 1'b1;
                    n_cbytes  = cnt;
                    n_last    = (r_left <= 8'(CHUNK_CHARS));
                    n_ocons   = (r_left <= 8'(CHUNK_CHARS)) ? r_consumed : 9'd0;
                    n_err     = ERR_NONE;
                    n_state   = S_OUT;
                end
            end

            // hold the item until the receiver takes it
            S_OUT: begin
                if (!r_valid) begin
                    // error entry: single last item with zero text
                    n_valid  = 1'b1;
                    n_chunk  = 64'd0;
                    n_cbytes = 4'd0;
                    n_ocons  = 9'd0;
                    n_last   = 1'b1;
                end else if (out_take) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_base  = r_base + 8'(CHUNK_CHARS);
                        n_left  = r_left - 8'(CHUNK_CHARS);
                        n_j     = 4'd0;
                        n_chunk = 64'd0;
                        n_state = S_TXT;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_cap_vld   <= 1'b0;
            r_max_jumps <= 8'd16;
            r_pos       <= '0;
            r_jumped    <= 1'b0;
            r_jc        <= 8'd0;
            r_consumed  <= 9'd0;
            r_tlen      <= 8'd0;
            r_wire      <= 8'd0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_cap_vld  <= n_cap_vld;
            r_pos      <= n_pos;
            r_jumped   <= n_jumped;
            r_jc       <= n_jc;
            r_consumed <= n_consumed;
            r_tlen     <= n_tlen;
            r_wire     <= n_wire;
            if (i_cfg_we) begin
                r_max_jumps <= i_cfg_data;
            end
        end
        r_rem     <= n_rem;
        r_ptr_hi  <= n_ptr_hi;
        r_base    <= n_base;
        r_left    <= n_left;
        r_j       <= n_j;
        r_cap_idx <= n_cap_idx;
        r_chunk   <= n_chunk;
        r_cbytes  <= n_cbytes;
        r_ocons   <= n_ocons;
        r_err     <= n_err;
        r_last    <= n_last;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_valid;
    assign o_text_chunk     = r_chunk;
    assign o_chunk_bytes    = r_cbytes;
    assign o_consumed_bytes = r_ocons;
    assign o_error_code     = r_err;
    assign o_last           = r_last;

endmodule

// ----- test/dns_name_decompressor_test.sv -----
// Testbench of dns_name_decompressor: directed and random label walks checked against a predictor.
module dns_name_decompressor_test
    import dnd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = 512;
    localparam int NAME_LIMIT  = 255;
    // Slowest quiet stretch is a 255-pointer loop; allow several times its length
    localparam int WATCHDOG_LIMIT = 5000;
    // Spare wait after the last result, before touching the register
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 50;

    // One result item of a decode
    typedef struct packed {
        logic [63:0] chunk;
        logic [3:0]  nchars;
        logic [8:0]  consumed;
        logic [1:0]  code;
        logic        is_last;
    } t_name_piece;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [7:0]  i_cfg_data  = 8'd0;
    logic        i_in_valid  = 1'b0;
    logic        i_action    = ACT_LOAD;
    logic [8:0]  i_address   = 9'd0;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [63:0] o_text_chunk;
    logic [3:0]  o_chunk_bytes;
    logic [8:0]  o_consumed_bytes;
    logic [1:0]  o_error_code;
    logic        o_last;

    // Predictor state: mirror of the packet store, which entries were loaded, and the jump limit
    logic [7:0]  packet_mirror [0:STORE_BYTES-1];
    bit          byte_written [0:STORE_BYTES-1];
    int          jump_limit = 16;
    t_name_piece expected_pieces [$];

    logic [7:0]  name_bytes [$];
    int          name_starts [$];
    int          items_sent = 0;
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          idling_on = 1'b1;

    dns_name_decompressor #(
        .PACKET_BYTES   (STORE_BYTES),
        .MAX_NAME_BYTES (NAME_LIMIT)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_address        (i_address),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_text_chunk     (o_text_chunk),
        .o_chunk_bytes    (o_chunk_bytes),
        .o_consumed_bytes (o_consumed_bytes),
        .o_error_code     (o_error_code),
        .o_last           (o_last)
    );

    // Clock, 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // Walk the mirrored store from start; hole is the first unloaded byte that the walk reads,
    // or -1, and pieces are queued only for a walk without a hole
    task automatic predict_decode(input logic [8:0] start, input bit commit, output int hole);
        int pos, wire_len, tlen, jumps, consumed, len, nres, cnt, base;
        bit jumped, walking;
        logic [1:0] fault;
        logic [7:0] b;
        logic [7:0] txt [0:255];
        t_name_piece piece;
        pos = start;
        wire_len = 0;
        tlen = 0;
        jumps = 0;
        consumed = 0;
        jumped = 1'b0;
        walking = 1'b1;
        fault = ERR_NONE;
        hole = -1;
        while (walking) begin
            if (pos >= STORE_BYTES) begin
                fault = ERR_RANGE;
                walking = 1'b0;
            end else if (!byte_written[pos]) begin
                hole = pos;
                walking = 1'b0;
            end else begin
                b = packet_mirror[pos];
                if (b == 8'd0) begin
                    // terminator
                    if (!jumped)
                        consumed += 1;
                    walking = 1'b0;
                end else if (b >= PTR_TAG) begin
                    // compression pointer
                    if (pos + 1 >= STORE_BYTES) begin
                        fault = ERR_RANGE;
                        walking = 1'b0;
                    end else if (jumps >= jump_limit) begin
                        fault = ERR_JUMPS;
                        walking = 1'b0;
                    end else if (!byte_written[pos + 1]) begin
                        hole = pos + 1;
                        walking = 1'b0;
                    end else begin
                        if (!jumped)
                            consumed += 2;
                        jumped = 1'b1;
                        jumps++;
                        pos = {b[5:0], packet_mirror[pos + 1]};
                    end
                end else begin
                    // plain label
                    len = b;
                    if (wire_len + len + 2 > NAME_LIMIT) begin
                        fault = ERR_TOO_LONG;
                        walking = 1'b0;
                    end else if (pos + len >= STORE_BYTES) begin
                        fault = ERR_RANGE;
                        walking = 1'b0;
                    end else begin
                        for (int i = 1; i <= len; i++) begin
                            if (hole < 0 && !byte_written[pos + i])
                                hole = pos + i;
                        end
                        if (hole >= 0) begin
                            walking = 1'b0;
                        end else begin
                            if (tlen > 0) begin
                                txt[tlen] = DOT_CHAR;
                                tlen++;
                            end
                            for (int i = 1; i <= len; i++) begin
                                txt[tlen] = packet_mirror[pos + i];
                                tlen++;
                            end
                            wire_len += len + 1;
                            if (!jumped)
                                consumed += len + 1;
                            pos += len + 1;
                        end
                    end
                end
            end
        end

        if (hole < 0 && commit) begin
            if (fault != ERR_NONE) begin
                piece = '0;
                piece.code = fault;
                piece.is_last = 1'b1;
                expected_pieces.push_back(piece);
            end else begin
                nres = (tlen + CHUNK_CHARS - 1) / CHUNK_CHARS;
                if (nres == 0)
                    nres = 1;
                for (int k = 0; k < nres; k++) begin
                    base = k * CHUNK_CHARS;
                    cnt = (tlen > base) ? tlen - base : 0;
                    if (cnt > CHUNK_CHARS)
                        cnt = CHUNK_CHARS;
                    piece = '0;
                    for (int i = 0; i < cnt; i++)
                        piece.chunk[8*i +: 8] = txt[base + i];
                    piece.nchars = cnt[3:0];
                    piece.is_last = (k == nres - 1);
                    piece.consumed = piece.is_last ? consumed[8:0] : 9'd0;
                    expected_pieces.push_back(piece);
                end
            end
        end
    endtask

    // Present one item at a falling edge, hold it until accepted, return at the next falling edge
    task automatic send_item(input logic act, input logic [8:0] addr, input logic [7:0] data);
        int hole;
        if (idling_on) begin
            while ($urandom_range(0, 99) < 38) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid  <= 1'b1;
        i_action    <= act;
        i_address   <= addr;
        i_data_byte <= data;
        do
            @(posedge i_clk);
        while (o_in_stall);
        if (act == ACT_DECODE) begin
            predict_decode(addr, 1'b1, hole);
        end else if (addr < STORE_BYTES) begin
            packet_mirror[addr] = data;
            byte_written[addr] = 1'b1;
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // Load a terminator into every unloaded byte that the walk would read, then decode
    task automatic decode_at(input logic [8:0] addr);
        int hole;
        predict_decode(addr, 1'b0, hole);
        while (hole >= 0) begin
            send_item(ACT_LOAD, 9'(hole), 8'd0);
            predict_decode(addr, 1'b0, hole);
        end
        send_item(ACT_DECODE, addr, 8'($urandom_range(0, 255)));
    endtask

    task automatic load_bytes(input int start);
        for (int i = 0; i < name_bytes.size(); i++)
            send_item(ACT_LOAD, 9'(start + i), name_bytes[i]);
    endtask

    // Hold off the sender until every queued piece has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (expected_pieces.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_jump_limit(input logic [7:0] value);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        jump_limit = value;
    endtask

    task automatic test_root_names();
        decode_at(9'd0);
        decode_at(9'd511);
    endtask

    task automatic test_label_text();
        // "abc.defg": exactly one full chunk
        name_bytes = '{8'h03, 8'h61, 8'h62, 8'h63, 8'h04, 8'h64, 8'h65, 8'h66, 8'h67, 8'h00};
        load_bytes(16);
        decode_at(9'd16);
        // zero and dot bytes inside labels, nine characters over two chunks
        name_bytes = '{8'h02, 8'h00, DOT_CHAR, 8'h06, 8'hc3, 8'hff, 8'h7a, 8'h80, 8'h01,
                       DOT_CHAR, 8'h00};
        load_bytes(30);
        decode_at(9'd30);
    endtask

    task automatic test_pointer_follow();
        // label then pointer to offset 16
        name_bytes = '{8'h01, 8'h78, 8'hc0, 8'h10};
        load_bytes(48);
        decode_at(9'd48);
        // pointer chain 56 -> 48 -> 16
        name_bytes = '{8'hc0, 8'h30};
        load_bytes(56);
        decode_at(9'd56);
        // pointer straight to the root
        name_bytes = '{8'hc0, 8'h00};
        load_bytes(66);
        decode_at(9'd66);
        // pointer to itself, reset jump limit
        name_bytes = '{8'hc0, 8'h3c};
        load_bytes(60);
        decode_at(9'd60);
    endtask

    task automatic test_jump_limit();
        set_jump_limit(8'd1);
        decode_at(9'd48);
        decode_at(9'd56);
        set_jump_limit(8'd255);
        decode_at(9'd60);
        decode_at(9'd56);
        set_jump_limit(8'd16);
    endtask

    task automatic test_out_of_range();
        // pointer to offset 0x3fff
        name_bytes = '{8'hff, 8'hff};
        load_bytes(64);
        decode_at(9'd64);
        // pointer to the first offset past the store
        name_bytes = '{8'hc2, 8'h00};
        load_bytes(70);
        decode_at(9'd70);
        // label running past the end, then terminator read past the end
        name_bytes = '{8'h05, 8'h02, 8'h61, 8'h62};
        load_bytes(508);
        decode_at(9'd508);
        decode_at(9'd509);
        // pointer in the last byte
        send_item(ACT_LOAD, 9'd511, PTR_TAG);
        decode_at(9'd511);
    endtask

    // Runs with no idling on either side: the long steady stretch
    task automatic test_name_length();
        idling_on = 1'b0;
        // 191-byte label plus 61-byte label: wire form exactly at the limit, 32 pieces
        name_bytes.delete();
        name_bytes.push_back(8'd191);
        for (int i = 0; i < 191; i++)
            name_bytes.push_back(8'($urandom_range(0, 255)));
        name_bytes.push_back(8'd61);
        for (int i = 0; i < 61; i++)
            name_bytes.push_back(8'($urandom_range(0, 255)));
        name_bytes.push_back(8'd0);
        load_bytes(100);
        decode_at(9'd100);
        // one byte more is too long
        send_item(ACT_LOAD, 9'd292, 8'd62);
        decode_at(9'd100);
        // longest single label alone
        send_item(ACT_LOAD, 9'd292, 8'd0);
        decode_at(9'd100);
        idling_on = 1'b1;
    endtask

    // Well-formed name with random labels, ending in a terminator, a pointer, or nothing
    task automatic send_random_name();
        int nlabels, len, base, roll;
        logic [13:0] off;
        name_bytes.delete();
        nlabels = $urandom_range(0, 4);
        for (int l = 0; l < nlabels; l++) begin
            roll = $urandom_range(0, 39);
            if (roll == 0 && name_bytes.size() == 0)
                len = $urandom_range(64, 191);
            else if (roll < 5)
                len = $urandom_range(13, 63);
            else
                len = $urandom_range(1, 12);
            name_bytes.push_back(8'(len));
            for (int i = 0; i < len; i++)
                name_bytes.push_back(8'($urandom_range(0, 255)));
        end
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            name_bytes.push_back(8'd0);
        end else if (roll < 92) begin
            if (roll < 85 && name_starts.size() > 0)
                off = 14'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
            else
                off = 14'($urandom_range(0, 16383));
            name_bytes.push_back({2'b11, off[13:8]});
            name_bytes.push_back(off[7:0]);
        end
        // otherwise the name is left unterminated and runs into whatever follows
        base = $urandom_range(0, STORE_BYTES - name_bytes.size());
        load_bytes(base);
        decode_at(9'(base));
        if (name_starts.size() >= 16)
            void'(name_starts.pop_front());
        name_starts.push_back(base);
    endtask

    task automatic run_random_phase(input int count, input bit steady);
        int first, roll;
        first = items_sent;
        idling_on = !steady;
        while (items_sent - first < count) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
                send_random_name();
            else if (roll < 75)
                decode_at(9'($urandom_range(0, STORE_BYTES - 1)));
            else if (roll < 95)
                send_item(ACT_LOAD, 9'($urandom_range(0, STORE_BYTES - 1)),
                          8'($urandom_range(0, 255)));
            else
                drain_results();
        end
        idling_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        run_random_phase(10, 1'b0);
        set_jump_limit(8'd1);
        run_random_phase(10, 1'b0);
        set_jump_limit(8'd255);
        run_random_phase(10, 1'b1);
        set_jump_limit(8'($urandom_range(2, 8)));
        run_random_phase(10, 1'b0);
    endtask

    // Receiver stall, changed at the falling edge
    always @(negedge i_clk)
        i_out_stall <= idling_on && ($urandom_range(0, 99) < 38);

    // Compare each accepted result with the oldest expected piece
    always @(posedge i_clk) begin
        t_name_piece want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pieces.size() == 0) begin
                report_mismatch($sformatf("unexpected item, text_chunk %h", o_text_chunk));
            end else begin
                want = expected_pieces.pop_front();
                if (o_text_chunk !== want.chunk)
                    report_mismatch($sformatf("text_chunk %h, want %h", o_text_chunk, want.chunk));
                if (o_chunk_bytes !== want.nchars)
                    report_mismatch($sformatf("chunk_bytes %0d, want %0d",
                                              o_chunk_bytes, want.nchars));
                if (o_consumed_bytes !== want.consumed)
                    report_mismatch($sformatf("consumed_bytes %0d, want %0d",
                                              o_consumed_bytes, want.consumed));
                if (o_error_code !== want.code)
                    report_mismatch($sformatf("error_code %0d, want %0d",
                                              o_error_code, want.code));
                if (o_last !== want.is_last)
                    report_mismatch($sformatf("last %b, want %b", o_last, want.is_last));
            end
        end
    end

    // Watchdog on cycles with no item moving on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[dns_name_decompressor] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_root_names();
        test_label_text();
        test_pointer_follow();
        test_jump_limit();
        test_out_of_range();
        test_name_length();
        test_random_traffic();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pieces.size() == 0) begin
            $display("[dns_name_decompressor] OK");
        end else begin
            $display("[dns_name_decompressor] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/dnd_pkg.sv
rtl/dnd_ram.sv
rtl/dns_name_decompressor.sv
test/dns_name_decompressor_test.sv
